>>> rtl/hrp_pkg.sv
// Package for the hex record parser and router.
// Holds the configuration types, register indexes, result codes and the digit decoder.
// No dependencies.
package hrp_pkg;

    localparam logic [2:0] REG_PROG_BASE = 3'd0;
    localparam logic [2:0] REG_PROG_WORDS = 3'd1;
    localparam logic [2:0] REG_CFG_BASE = 3'd2;
    localparam logic [2:0] REG_CFG_WORDS = 3'd3;
    localparam logic [2:0] REG_DATA_BASE = 3'd4;
    localparam logic [2:0] REG_DATA_WORDS = 3'd5;
    localparam logic [2:0] REG_WORD_MASK = 3'd6;

    localparam logic [15:0] RST_PROG_BASE = 16'd0;
    localparam logic [15:0] RST_PROG_WORDS = 16'd8192;
    localparam logic [15:0] RST_CFG_BASE = 16'd16384;
    localparam logic [15:0] RST_CFG_WORDS = 16'd8;
    localparam logic [15:0] RST_DATA_BASE = 16'd16896;
    localparam logic [15:0] RST_DATA_WORDS = 16'd256;
    localparam logic [15:0] RST_WORD_MASK = 16'd16383;

    localparam logic [1:0] EV_WRITE = 2'd0;
    localparam logic [1:0] EV_END = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;

    localparam logic [1:0] RG_PROG = 2'd0;
    localparam logic [1:0] RG_CFG = 2'd1;
    localparam logic [1:0] RG_DATA = 2'd2;

    localparam logic [7:0] CHR_COLON = 8'h3a;
    localparam logic [7:0] CHR_DIG_0 = 8'h30;
    localparam logic [7:0] CHR_DIG_9 = 8'h39;
    localparam logic [7:0] CHR_UP_A = 8'h41;
    localparam logic [7:0] CHR_UP_F = 8'h46;
    localparam logic [7:0] CHR_LO_A = 8'h61;
    localparam logic [7:0] CHR_LO_F = 8'h66;
    localparam logic [7:0] TYPE_EOF = 8'h01;

    typedef struct packed {
        logic [15:0] prog_base;
        logic [15:0] prog_words;
        logic [15:0] cfg_base;
        logic [15:0] cfg_words;
        logic [15:0] data_base;
        logic [15:0] data_words;
        logic [15:0] word_mask;
    } t_cfg;

    typedef struct packed {
        logic        prog;
        logic        cfg;
        logic        data;
        logic [15:0] value;
    } t_base_load;

    typedef struct packed {
        logic        hit;
        logic [1:0]  region;
        logic [14:0] index;
        logic [15:0] value;
    } t_route;

    // Any character that is not a hex digit decodes as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= CHR_DIG_0 && c <= CHR_DIG_9) begin
            v = c[3:0];
        end else if ((c >= CHR_UP_A && c <= CHR_UP_F) || (c >= CHR_LO_A && c <= CHR_LO_F)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

>>> rtl/hex_record_parser_router.sv
// Top level of the hex record parser and router.
// Holds the input register and connects hrp_cfg_regs and hrp_core; depends on hrp_pkg.
//
// Usage: the input channel carries one ASCII character per request (i_in_valid,
// o_in_stall, i_in_char). Characters before a colon are ignored; each record
// gives a byte count, a 16-bit address and a type, then little-endian words.
// The output channel (o_out_valid, i_out_stall) carries at most one result per
// character: a word write with region, index and mask-based value, an end event with
// the used word counts of all three regions, or an address error.
// A character is accepted into the input register, and its result is registered
// in the result register when the parse step takes it from there. One character
// is accepted every cycle while the result register is not stalled; the parse step
// between the input register and the result register sets that rate. After an end
// or error result every further character is accepted and dropped until reset.
// Reset (synchronous, active low) loads the register defaults and waits for a
// colon. While the result register holds a stalled result, a character already
// in the input register waits there and o_in_stall is raised.
// Configuration writes through i_cfg_we should be made only while no character
// is in flight.
module hex_record_parser_router (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_char,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_res,
    output logic [1:0]  o_region,
    output logic [14:0] o_word_index,
    output logic [15:0] o_word_value,
    output logic [15:0] o_prog_used,
    output logic [15:0] o_cfg_used,
    output logic [15:0] o_data_used,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import hrp_pkg::*;

    logic       r_in_vld, n_in_vld;
    logic [7:0] r_in_char, n_in_char;
    logic       adv;
    logic       in_accept;
    t_cfg       cfg;
    t_base_load base_load;

    assign o_in_stall = r_in_vld && !adv;
    assign in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_vld = r_in_vld;
        n_in_char = r_in_char;
        if (in_accept) begin
            n_in_vld = 1'b1;
            n_in_char = i_in_char;
        end else if (adv) begin
            n_in_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_in_char <= 8'd0;
        end else begin
            r_in_vld <= n_in_vld;
            r_in_char <= n_in_char;
        end
    end

    hrp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_base_load (base_load)
    );

    hrp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_vld   (r_in_vld),
        .i_char       (r_in_char),
        .o_adv        (adv),
        .i_cfg        (cfg),
        .i_base_load  (base_load),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_res  (o_event_res),
        .o_region     (o_region),
        .o_word_index (o_word_index),
        .o_word_value (o_word_value),
        .o_prog_used  (o_prog_used),
        .o_cfg_used   (o_cfg_used),
        .o_data_used  (o_data_used)
    );

endmodule

>>> rtl/hrp_cfg_regs.sv
// Configuration register file of the hex record parser and router.
// Depends on hrp_pkg for the register indexes, reset values and types.
module hrp_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output hrp_pkg::t_cfg     o_cfg,
    output hrp_pkg::t_base_load o_base_load
);
    import hrp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PROG_BASE: n_cfg.prog_base = i_cfg_data;
                REG_PROG_WORDS: n_cfg.prog_words = i_cfg_data;
                REG_CFG_BASE: n_cfg.cfg_base = i_cfg_data;
                REG_CFG_WORDS: n_cfg.cfg_words = i_cfg_data;
                REG_DATA_BASE: n_cfg.data_base = i_cfg_data;
                REG_DATA_WORDS: n_cfg.data_words = i_cfg_data;
                REG_WORD_MASK: n_cfg.word_mask = i_cfg_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prog_base <= RST_PROG_BASE;
            r_cfg.prog_words <= RST_PROG_WORDS;
            r_cfg.cfg_base <= RST_CFG_BASE;
            r_cfg.cfg_words <= RST_CFG_WORDS;
            r_cfg.data_base <= RST_DATA_BASE;
            r_cfg.data_words <= RST_DATA_WORDS;
            r_cfg.word_mask <= RST_WORD_MASK;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // A base write also restarts the matching highest-address marker.
    assign o_base_load.prog = i_cfg_we && (i_cfg_index == REG_PROG_BASE);
    assign o_base_load.cfg = i_cfg_we && (i_cfg_index == REG_CFG_BASE);
    assign o_base_load.data = i_cfg_we && (i_cfg_index == REG_DATA_BASE);
    assign o_base_load.value = i_cfg_data;
    assign o_cfg = r_cfg;

endmodule

>>> rtl/hrp_route.sv
// Address window matcher of the hex record parser and router.
// Picks the program, config or data region for a word and forms its index and value.
// Depends on hrp_pkg.
module hrp_route (
    input  logic [16:0]   i_addr,
    input  logic [15:0]   i_word,
    input  hrp_pkg::t_cfg i_cfg,
    output hrp_pkg::t_route o_route
);
    import hrp_pkg::*;

    logic        prog_hit;
    logic        cfg_hit;
    logic        data_hit;
    logic [16:0] diff;

    function automatic logic in_window(input logic [16:0] addr, input logic [15:0] base,
                                       input logic [15:0] words);
        logic [17:0] limit;
        limit = {2'b00, base} + {1'b0, words, 1'b0};
        return ({1'b0, base} <= addr) && ({1'b0, addr} < limit);
    endfunction

    always_comb begin
        prog_hit = in_window(i_addr, i_cfg.prog_base, i_cfg.prog_words);
        cfg_hit = in_window(i_addr, i_cfg.cfg_base, i_cfg.cfg_words);
        data_hit = in_window(i_addr, i_cfg.data_base, i_cfg.data_words);
        o_route.hit = prog_hit || cfg_hit || data_hit;
        if (prog_hit) begin
            o_route.region = RG_PROG;
            diff = i_addr - {1'b0, i_cfg.prog_base};
            o_route.value = i_word & i_cfg.word_mask;
        end else if (cfg_hit) begin
            o_route.region = RG_CFG;
            diff = i_addr - {1'b0, i_cfg.cfg_base};
            o_route.value = i_word & i_cfg.word_mask;
        end else begin
            o_route.region = RG_DATA;
            diff = i_addr - {1'b0, i_cfg.data_base};
            o_route.value = {i_cfg.word_mask[15:8], i_word[7:0]};
        end
        o_route.index = diff[15:1];
    end

endmodule

>>> rtl/hrp_core.sv
// Record parser core: parse state, highest-address markers and the result register.
// Uses hrp_route for the window match and hrp_pkg for types and codes.
module hrp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_char_vld,
    input  logic [7:0]           i_char,
    output logic                 o_adv,
    input  hrp_pkg::t_cfg        i_cfg,
    input  hrp_pkg::t_base_load  i_base_load,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_event_res,
    output logic [1:0]           o_region,
    output logic [14:0]          o_word_index,
    output logic [15:0]          o_word_value,
    output logic [15:0]          o_prog_used,
    output logic [15:0]          o_cfg_used,
    output logic [15:0]          o_data_used
);
    import hrp_pkg::*;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_COUNT,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_SUM
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_dc, n_dc;
    logic [7:0]  r_bc, n_bc;
    logic [15:0] r_ra, n_ra;
    logic [7:0]  r_bo, n_bo;
    logic [15:0] r_acc, n_acc;
    logic [16:0] r_prog_hi, n_prog_hi;
    logic [16:0] r_cfg_hi, n_cfg_hi;
    logic [16:0] r_data_hi, n_data_hi;
    logic        r_halted, n_halted;
    logic        r_out_vld, n_out_vld;
    logic [1:0]  r_out_event, n_out_event;
    logic [1:0]  r_out_region, n_out_region;
    logic [14:0] r_out_index, n_out_index;
    logic [15:0] r_out_value, n_out_value;
    logic [15:0] r_out_prog_used, n_out_prog_used;
    logic [15:0] r_out_cfg_used, n_out_cfg_used;
    logic [15:0] r_out_data_used, n_out_data_used;

    logic        proc;
    logic [15:0] acc_shift;
    logic [2:0]  dc_inc;
    logic [16:0] addr;
    logic [15:0] word;
    logic        last_word;
    t_route      route;

    function automatic logic [15:0] used_count(input logic [16:0] highest,
                                               input logic [15:0] base);
        logic [16:0] h;
        logic [16:0] d;
        h = (highest < {1'b0, base}) ? {1'b0, base} : highest;
        d = h - {1'b0, base};
        return d[16:1] + 16'd1;
    endfunction

    assign o_adv = !r_out_vld || !i_out_stall;
    assign proc = i_char_vld && o_adv && !r_halted;
    assign acc_shift = {r_acc[11:0], hex_value(i_char)};
    assign dc_inc = r_dc + 3'd1;
    assign addr = {1'b0, r_ra} + {9'd0, r_bo};
    assign word = {acc_shift[7:0], acc_shift[15:8]};
    assign last_word = ({1'b0, r_bo} + 9'd2) >= {1'b0, r_bc};

    hrp_route u_route (
        .i_addr  (addr),
        .i_word  (word),
        .i_cfg   (i_cfg),
        .o_route (route)
    );

    always_comb begin
        n_phase = r_phase;
        n_dc = r_dc;
        n_bc = r_bc;
        n_ra = r_ra;
        n_bo = r_bo;
        n_acc = r_acc;
        n_prog_hi = r_prog_hi;
        n_cfg_hi = r_cfg_hi;
        n_data_hi = r_data_hi;
        n_halted = r_halted;
        n_out_vld = o_adv ? 1'b0 : r_out_vld;
        n_out_event = r_out_event;
        n_out_region = r_out_region;
        n_out_index = r_out_index;
        n_out_value = r_out_value;
        n_out_prog_used = r_out_prog_used;
        n_out_cfg_used = r_out_cfg_used;
        n_out_data_used = r_out_data_used;

        if (proc) begin
            n_dc = dc_inc;
            n_acc = acc_shift;
            case (r_phase)
                PH_WAIT: begin
                    n_dc = r_dc;
                    n_acc = r_acc;
                    if (i_char == CHR_COLON) begin
                        n_phase = PH_COUNT;
                        n_dc = 3'd0;
                        n_acc = 16'd0;
                    end
                end
                PH_COUNT: begin
                    if (dc_inc >= 3'd2) begin
                        n_bc = acc_shift[7:0];
                        n_phase = PH_ADDR;
                        n_dc = 3'd0;
                        n_acc = 16'd0;
                    end
                end
                PH_ADDR: begin
                    if (dc_inc >= 3'd4) begin
                        n_ra = acc_shift;
                        n_phase = PH_TYPE;
                        n_dc = 3'd0;
                        n_acc = 16'd0;
                    end
                end
                PH_TYPE: begin
                    if (dc_inc >= 3'd2) begin
                        if (acc_shift[7:0] == TYPE_EOF) begin
                            n_halted = 1'b1;
                            n_out_vld = 1'b1;
                            n_out_event = EV_END;
                            n_out_region = RG_PROG;
                            n_out_index = '0;
                            n_out_value = '0;
                            n_out_prog_used = used_count(r_prog_hi, i_cfg.prog_base);
                            n_out_cfg_used = used_count(r_cfg_hi, i_cfg.cfg_base);
                            n_out_data_used = used_count(r_data_hi, i_cfg.data_base);
                        end else begin
                            n_bo = 8'd0;
                            n_phase = (r_bc == 8'd0) ? PH_SUM : PH_DATA;
                            n_dc = 3'd0;
                            n_acc = 16'd0;
                        end
                    end
                end
                PH_DATA: begin
                    if (dc_inc >= 3'd4) begin
                        n_out_vld = 1'b1;
                        n_out_prog_used = '0;
                        n_out_cfg_used = '0;
                        n_out_data_used = '0;
                        if (route.hit) begin
                            n_out_event = EV_WRITE;
                            n_out_region = route.region;
                            n_out_index = route.index;
                            n_out_value = route.value;
                            if (route.region == RG_PROG && addr > r_prog_hi) begin
                                n_prog_hi = addr;
                            end
                            if (route.region == RG_CFG && addr > r_cfg_hi) begin
                                n_cfg_hi = addr;
                            end
                            if (route.region == RG_DATA && addr > r_data_hi) begin
                                n_data_hi = addr;
                            end
                            if (last_word) begin
                                n_phase = PH_SUM;
                            end else begin
                                n_bo = r_bo + 8'd2;
                            end
                            n_dc = 3'd0;
                            n_acc = 16'd0;
                        end else begin
                            n_halted = 1'b1;
                            n_out_event = EV_ERROR;
                            n_out_region = RG_PROG;
                            n_out_index = '0;
                            n_out_value = '0;
                        end
                    end
                end
                PH_SUM: begin
                    if (dc_inc >= 3'd2) begin
                        n_phase = PH_WAIT;
                        n_dc = 3'd0;
                        n_acc = 16'd0;
                    end
                end
                default: begin
                    n_phase = PH_WAIT;
                    n_dc = 3'd0;
                    n_acc = 16'd0;
                end
            endcase
        end

        if (i_base_load.prog) begin
            n_prog_hi = {1'b0, i_base_load.value};
        end
        if (i_base_load.cfg) begin
            n_cfg_hi = {1'b0, i_base_load.value};
        end
        if (i_base_load.data) begin
            n_data_hi = {1'b0, i_base_load.value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_dc <= 3'd0;
            r_bc <= 8'd0;
            r_ra <= 16'd0;
            r_bo <= 8'd0;
            r_acc <= 16'd0;
            r_prog_hi <= {1'b0, RST_PROG_BASE};
            r_cfg_hi <= {1'b0, RST_CFG_BASE};
            r_data_hi <= {1'b0, RST_DATA_BASE};
            r_halted <= 1'b0;
            r_out_vld <= 1'b0;
            r_out_event <= EV_WRITE;
            r_out_region <= RG_PROG;
            r_out_index <= '0;
            r_out_value <= '0;
            r_out_prog_used <= '0;
            r_out_cfg_used <= '0;
            r_out_data_used <= '0;
        end else begin
            r_phase <= n_phase;
            r_dc <= n_dc;
            r_bc <= n_bc;
            r_ra <= n_ra;
            r_bo <= n_bo;
            r_acc <= n_acc;
            r_prog_hi <= n_prog_hi;
            r_cfg_hi <= n_cfg_hi;
            r_data_hi <= n_data_hi;
            r_halted <= n_halted;
            r_out_vld <= n_out_vld;
            r_out_event <= n_out_event;
            r_out_region <= n_out_region;
            r_out_index <= n_out_index;
            r_out_value <= n_out_value;
            r_out_prog_used <= n_out_prog_used;
            r_out_cfg_used <= n_out_cfg_used;
            r_out_data_used <= n_out_data_used;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_event_res = r_out_event;
    assign o_region = r_out_region;
    assign o_word_index = r_out_index;
    assign o_word_value = r_out_value;
    assign o_prog_used = r_out_prog_used;
    assign o_cfg_used = r_out_cfg_used;
    assign o_data_used = r_out_data_used;

    // Once halted, the block never raises a new result.
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halted && !r_out_vld) |=> !r_out_vld)
        else $error("result raised after halt");

    // End and error results always come with the halt flag set.
    a_final_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_event == EV_END || r_out_event == EV_ERROR)) |-> r_halted)
        else $error("end or error result without halt");

    // No field is longer than four digits.
    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dc <= 3'd4)
        else $error("digit count out of range");

    // Waiting for a colon always starts from a cleared digit count.
    a_wait_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT) |-> (r_dc == 3'd0))
        else $error("digit count not cleared while waiting");

endmodule
